/* sv/dq_pkg.sv */
package dq_pkg;

  localparam int WORD_W  = 32;
  localparam int KIND_W  = 3;
  localparam int COUNT_W = 11;

  localparam logic [KIND_W-1:0] KIND_PUSH_FRONT = 3'd0;
  localparam logic [KIND_W-1:0] KIND_PUSH_BACK  = 3'd1;
  localparam logic [KIND_W-1:0] KIND_POP_FRONT  = 3'd2;
  localparam logic [KIND_W-1:0] KIND_POP_BACK   = 3'd3;
  localparam logic [KIND_W-1:0] KIND_NOP        = 3'd4;

  localparam logic signed [WORD_W-1:0] EMPTY_WORD = -32'sd1;

  typedef struct packed {
    logic [KIND_W-1:0]        kind;
    logic signed [WORD_W-1:0] value;
  } in_item_t;

  typedef struct packed {
    logic signed [WORD_W-1:0] popped_value;
    logic                     pop_ok;
    logic                     push_dropped;
    logic [COUNT_W-1:0]       count;
    logic                     is_empty;
    logic signed [WORD_W-1:0] front_value;
    logic signed [WORD_W-1:0] back_value;
  } out_item_t;

  // one shift command for a whole chain; the head is cell 0
  typedef struct packed {
    logic              ins_head;
    logic              ins_tail;
    logic              rem_head;
    logic              rem_tail;
    logic [WORD_W-1:0] word;
  } shift_cmd_t;

endpackage

/* sv/dq_cell.sv */
module dq_cell (
  input  logic                       clk,
  input  logic                       rst_n,
  input  dq_pkg::shift_cmd_t         cmd,
  input  logic [dq_pkg::WORD_W-1:0]  left_word,
  input  logic                       left_occ,
  input  logic [dq_pkg::WORD_W-1:0]  right_word,
  input  logic                       right_occ,
  output logic [dq_pkg::WORD_W-1:0]  word_r,
  output logic                       occ_r
);
  import dq_pkg::*;

  logic [WORD_W-1:0] word_nxt;
  logic              occ_nxt;

  always_comb begin
    word_nxt = word_r;
    occ_nxt  = occ_r;
    if (cmd.ins_head) begin
      word_nxt = left_word;
      occ_nxt  = left_occ;
    end else if (cmd.rem_head) begin
      word_nxt = right_word;
      occ_nxt  = right_occ;
    end else if (cmd.ins_tail && !occ_r && left_occ) begin
      // first free cell after the occupied run takes the new item
      word_nxt = cmd.word;
      occ_nxt  = 1'b1;
    end else if (cmd.rem_tail && occ_r && !right_occ) begin
      occ_nxt  = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      occ_r <= 1'b0;
    end else begin
      occ_r <= occ_nxt;
    end
  end

  always_ff @(posedge clk) begin
    word_r <= word_nxt;
  end

endmodule

/* sv/dq_chain.sv */
module dq_chain #(
  parameter int DEPTH = 1024
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  dq_pkg::shift_cmd_t         cmd,
  output logic [dq_pkg::WORD_W-1:0]  head_word,
  output logic                       head_occ
);
  import dq_pkg::*;

  logic [WORD_W-1:0] word [DEPTH];
  logic              occ  [DEPTH];

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [WORD_W-1:0] lw;
    logic              lo;
    logic [WORD_W-1:0] rw;
    logic              ro;

    // cell 0 sees the incoming word as an occupied left neighbour
    if (i == 0) begin : g_first
      assign lw = cmd.word;
      assign lo = 1'b1;
    end else begin : g_mid_l
      assign lw = word[i-1];
      assign lo = occ[i-1];
    end

    if (i == DEPTH-1) begin : g_last
      assign rw = '0;
      assign ro = 1'b0;
    end else begin : g_mid_r
      assign rw = word[i+1];
      assign ro = occ[i+1];
    end

    dq_cell u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .cmd        (cmd),
      .left_word  (lw),
      .left_occ   (lo),
      .right_word (rw),
      .right_occ  (ro),
      .word_r     (word[i]),
      .occ_r      (occ[i])
    );
  end

  assign head_word = word[0];
  assign head_occ  = occ[0];

endmodule

/* sv/double_ended_queue_top.sv */
// Bounded double-ended queue of signed 32-bit words, up to DEPTH entries.
// Every accepted item (push front, push back, pop front, pop back or no
// operation) gives one result in the next cycle: the popped word with its ok
// flag, a flag for a push dropped on a full queue, the count, an empty flag
// and the front and back words (-1 when empty). One item is taken per cycle
// while results are being taken, also in the cycle its predecessor's result
// is taken, so the sustained rate is one item per cycle; each operation
// finishes in the cycle in which both shift chains move. Storage is two
// rows of DEPTH cells holding the queue in opposite order, so the front
// sits in cell 0 of one row and the back in cell 0 of the other; no cell is
// ever searched or muxed. The count output carries the low 11 bits of the
// element count. No clearing pass is needed after reset.
module double_ended_queue_top #(
  parameter int DEPTH = 1024
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  dq_pkg::in_item_t  in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output dq_pkg::out_item_t out_data
);
  import dq_pkg::*;

  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [CNT_W-1:0]  count_r, count_nxt;
  logic              out_valid_r;
  logic [WORD_W-1:0] popped_r, popped_nxt;
  logic              pop_ok_r, pop_ok_nxt;
  logic              dropped_r, dropped_nxt;

  logic              accept;
  logic              is_full, is_empty;
  logic              do_push_f, do_push_b, do_pop_f, do_pop_b;
  logic              want_push_f, want_push_b, want_pop_f, want_pop_b;

  shift_cmd_t        cmd_fwd, cmd_rev;
  logic [WORD_W-1:0] fwd_word, rev_word;
  logic              fwd_occ, rev_occ;

  assign in_ready = !out_valid_r || out_ready;
  assign accept   = in_valid && in_ready;
  assign is_full  = (count_r == CNT_W'(DEPTH));
  assign is_empty = (count_r == '0);

  always_comb begin
    want_push_f = 1'b0;
    want_push_b = 1'b0;
    want_pop_f  = 1'b0;
    want_pop_b  = 1'b0;
    unique case (in_data.kind)
      KIND_PUSH_FRONT: want_push_f = 1'b1;
      KIND_PUSH_BACK:  want_push_b = 1'b1;
      KIND_POP_FRONT:  want_pop_f  = 1'b1;
      KIND_POP_BACK:   want_pop_b  = 1'b1;
      KIND_NOP:        ;
      default:         ;
    endcase
  end

  assign do_push_f = accept && want_push_f && !is_full;
  assign do_push_b = accept && want_push_b && !is_full;
  assign do_pop_f  = accept && want_pop_f && !is_empty;
  assign do_pop_b  = accept && want_pop_b && !is_empty;

  // forward row keeps the front in cell 0, reverse row keeps the back there
  always_comb begin
    cmd_fwd.ins_head = do_push_f;
    cmd_fwd.ins_tail = do_push_b;
    cmd_fwd.rem_head = do_pop_f;
    cmd_fwd.rem_tail = do_pop_b;
    cmd_fwd.word     = in_data.value;
    cmd_rev.ins_head = do_push_b;
    cmd_rev.ins_tail = do_push_f;
    cmd_rev.rem_head = do_pop_b;
    cmd_rev.rem_tail = do_pop_f;
    cmd_rev.word     = in_data.value;
  end

  dq_chain #(.DEPTH(DEPTH)) u_fwd (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd_fwd),
    .head_word (fwd_word),
    .head_occ  (fwd_occ)
  );

  dq_chain #(.DEPTH(DEPTH)) u_rev (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd_rev),
    .head_word (rev_word),
    .head_occ  (rev_occ)
  );

  always_comb begin
    count_nxt = count_r;
    if (do_push_f || do_push_b) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (do_pop_f || do_pop_b) begin
      count_nxt = count_r - CNT_W'(1);
    end
    popped_nxt  = EMPTY_WORD;
    if (do_pop_f) begin
      popped_nxt = fwd_word;
    end else if (do_pop_b) begin
      popped_nxt = rev_word;
    end
    pop_ok_nxt  = do_pop_f || do_pop_b;
    dropped_nxt = accept && (want_push_f || want_push_b) && is_full;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r <= count_nxt;
      if (accept) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      popped_r  <= popped_nxt;
      pop_ok_r  <= pop_ok_nxt;
      dropped_r <= dropped_nxt;
    end
  end

  // the rows only move on an accepted item, so their heads hold with the result
  always_comb begin
    out_data.popped_value = popped_r;
    out_data.pop_ok       = pop_ok_r;
    out_data.push_dropped = dropped_r;
    out_data.count        = COUNT_W'(count_r);
    out_data.is_empty     = is_empty;
    out_data.front_value  = fwd_occ ? fwd_word : EMPTY_WORD;
    out_data.back_value   = rev_occ ? rev_word : EMPTY_WORD;
  end

  assign out_valid = out_valid_r;

endmodule

/* verif/dq_result_check.sv */
module dq_result_check #(
  parameter int DEPTH = 1024
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_ready,
  input  dq_pkg::in_item_t  in_data,
  input  logic              out_valid,
  input  logic              out_ready,
  input  dq_pkg::out_item_t out_data,
  output int                mismatches,
  output int                awaited
);
  import dq_pkg::*;

  // queue contents as a ring: head_pos is the front, fill the occupancy
  logic signed [WORD_W-1:0] ring [DEPTH];
  int unsigned              head_pos;
  int unsigned              fill;
  out_item_t                views_due [$];

  function automatic out_item_t apply_op(input in_item_t it);
    out_item_t r;
    r              = '0;
    r.popped_value = EMPTY_WORD;
    r.front_value  = EMPTY_WORD;
    r.back_value   = EMPTY_WORD;
    case (it.kind)
      KIND_PUSH_FRONT, KIND_PUSH_BACK: begin
        if (fill >= DEPTH) begin
          r.push_dropped = 1'b1;
        end else begin
          if (it.kind == KIND_PUSH_FRONT) begin
            head_pos       = (head_pos + DEPTH - 1) % DEPTH;
            ring[head_pos] = it.value;
          end else begin
            ring[(head_pos + fill) % DEPTH] = it.value;
          end
          fill++;
        end
      end
      KIND_POP_FRONT, KIND_POP_BACK: begin
        if (fill != 0) begin
          if (it.kind == KIND_POP_FRONT) begin
            r.popped_value = ring[head_pos];
            head_pos       = (head_pos + 1) % DEPTH;
          end else begin
            r.popped_value = ring[(head_pos + fill - 1) % DEPTH];
          end
          fill--;
          r.pop_ok = 1'b1;
        end
      end
      default: ;
    endcase
    if (fill != 0) begin
      r.front_value = ring[head_pos];
      r.back_value  = ring[(head_pos + fill - 1) % DEPTH];
    end
    r.count    = COUNT_W'(fill);
    r.is_empty = (fill == 0);
    return r;
  endfunction

  task automatic check_field(input string field, input logic [WORD_W-1:0] want,
                             input logic [WORD_W-1:0] got);
    if (got !== want) begin
      $display("%0t: %s expected %h got %h", $time, field, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    out_item_t want;
    if (!rst_n) begin
      head_pos   = 0;
      fill       = 0;
      mismatches = 0;
      views_due.delete();
      awaited <= 0;
    end else begin
      // predict first so a same-edge result still pairs with the oldest item
      if (in_valid && in_ready) views_due.insert(views_due.size(), apply_op(in_data));
      if (out_valid && out_ready) begin
        if (views_due.size() == 0) begin
          $display("%0t: result with no item outstanding, expected none got %p",
                   $time, out_data);
          mismatches++;
        end else begin
          want = views_due[0];
          views_due.delete(0);
          check_field("popped_value", want.popped_value, out_data.popped_value);
          check_field("pop_ok", want.pop_ok, out_data.pop_ok);
          check_field("push_dropped", want.push_dropped, out_data.push_dropped);
          check_field("count", want.count, out_data.count);
          check_field("is_empty", want.is_empty, out_data.is_empty);
          check_field("front_value", want.front_value, out_data.front_value);
          check_field("back_value", want.back_value, out_data.back_value);
        end
      end
      awaited <= views_due.size();
    end
  end

endmodule

/* verif/double_ended_queue_top_test.sv */
module double_ended_queue_top_test;
  import dq_pkg::*;

  localparam int DEPTH      = 1024;
  localparam int IDLE_LIMIT = 1000;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_ready;
  in_item_t  in_data;
  logic      out_valid;
  logic      out_ready;
  out_item_t out_data;

  int mismatches;
  int awaited;
  int idle_cycles = 0;
  int level       = 0;  // occupancy as seen by the sender, only steers stimulus
  int sent        = 0;
  bit send_quiet;
  bit take_quiet;

  double_ended_queue_top #(.DEPTH(DEPTH)) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  dq_result_check #(.DEPTH(DEPTH)) results (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data),
    .mismatches (mismatches),
    .awaited    (awaited)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == IDLE_LIMIT) begin
      $display("double_ended_queue_top_test NOT OK");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // result side: random stalls per item, with quiet stretches
  initial begin
    int stall;
    int taken;
    taken = 0;
    forever begin
      if (taken % 64 == 0) take_quiet = ($urandom_range(0, 3) == 0);
      stall = take_quiet ? 0 : $urandom_range(0, 19);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      taken++;
    end
  end

  task automatic send_op(input logic [KIND_W-1:0] kind, input logic signed [WORD_W-1:0] word);
    int gap;
    if (sent % 64 == 0) send_quiet = ($urandom_range(0, 3) == 0);
    gap = send_quiet ? 0 : $urandom_range(0, 19);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_data.kind  <= kind;
    in_data.value <= word;
    do @(posedge clk); while (!in_ready);
    sent++;
    case (kind)
      KIND_PUSH_FRONT, KIND_PUSH_BACK: if (level < DEPTH) level++;
      KIND_POP_FRONT, KIND_POP_BACK:   if (level > 0) level--;
      default: ;
    endcase
  endtask

  function automatic logic signed [WORD_W-1:0] rand_word();
    case ($urandom_range(0, 9))
      0:       return 32'sh7fff_ffff;
      1:       return 32'sh8000_0000;
      2:       return '0;
      3:       return EMPTY_WORD;
      default: return $urandom();
    endcase
  endfunction

  // one random item: push_pct and pop_pct in percent, the rest no-ops or unused kinds
  task automatic mix_op(input int push_pct, input int pop_pct);
    int                roll;
    logic [KIND_W-1:0] kind;
    roll = $urandom_range(0, 99);
    if (roll < push_pct)
      kind = $urandom_range(0, 1) ? KIND_PUSH_BACK : KIND_PUSH_FRONT;
    else if (roll < push_pct + pop_pct)
      kind = $urandom_range(0, 1) ? KIND_POP_BACK : KIND_POP_FRONT;
    else if ($urandom_range(0, 3) == 0)
      kind = KIND_NOP;
    else
      kind = KIND_NOP + KIND_W'($urandom_range(1, 3));
    send_op(kind, rand_word());
  endtask

  // sender holds off until every outstanding result is back
  task automatic hold_for_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (awaited != 0);
  endtask

  initial begin
    rst_n    <= 1'b0;
    in_valid <= 1'b0;
    in_data  <= '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // pops on an empty queue, no-ops and the unused kinds
    send_op(KIND_POP_FRONT, 32'sd5);
    send_op(KIND_POP_BACK, 32'sd6);
    send_op(KIND_NOP, 32'sh7fff_ffff);
    send_op(KIND_NOP + 3'd1, 32'sh8000_0000);
    send_op(KIND_NOP + 3'd2, EMPTY_WORD);
    send_op(KIND_NOP + 3'd3, '0);
    // extremes of the word, ends checked in both orders
    send_op(KIND_PUSH_FRONT, 32'sh7fff_ffff);
    send_op(KIND_PUSH_BACK, 32'sh8000_0000);
    send_op(KIND_PUSH_FRONT, EMPTY_WORD);
    send_op(KIND_PUSH_BACK, '0);
    send_op(KIND_POP_BACK, 32'sd1);
    send_op(KIND_POP_FRONT, 32'sd2);
    send_op(KIND_POP_FRONT, 32'sd3);
    send_op(KIND_POP_BACK, 32'sd4);
    send_op(KIND_POP_FRONT, 32'sd7);
    // head wraps below slot zero
    send_op(KIND_PUSH_BACK, 32'sd1);
    send_op(KIND_PUSH_FRONT, 32'sd2);
    send_op(KIND_PUSH_BACK, 32'sd3);
    send_op(KIND_POP_FRONT, '0);
    send_op(KIND_POP_BACK, '0);
    send_op(KIND_POP_BACK, '0);
    send_op(KIND_POP_BACK, '0);
    hold_for_results();

    repeat (200) mix_op(45, 45);
    // fill to the brim, then linger at full so pushes get dropped
    while (level < DEPTH) mix_op(95, 3);
    repeat (60) mix_op(60, 30);
    hold_for_results();
    // drain to empty, then linger there so pops fail
    while (level > 0) mix_op(3, 95);
    repeat (60) mix_op(30, 60);
    repeat (200) mix_op(45, 45);

    in_valid <= 1'b0;
    do @(posedge clk); while (awaited != 0);
    repeat (20) @(posedge clk);
    if (mismatches == 0)
      $display("double_ended_queue_top_test OK");
    else
      $display("double_ended_queue_top_test NOT OK");
    $finish;
  end

endmodule
